// ===== rtl/core/ufs_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sequence filter package
// Shared constants, the burst type passed from front to back, and the
// lead byte classifier.
// ----------------------------------------------------------------------------
package ufs_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned MAX_BURST   = 4;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] PAT_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] PAT_LEAD3  = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] PAT_LEAD4  = 8'hF0;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] PAT_CONT   = 8'h80;

    // Sequence lengths; zero means no sequence open
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    // One group of results caused by a single input byte
    typedef struct packed {
        logic [MAX_BURST-1:0][BYTE_W-1:0] bytes;
        logic [1:0]                       last_idx;
        logic                             data_valid;
        logic                             msg_end;
    } ufs_burst_t;

    // Total sequence length opened by a lead byte, zero if not a lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = LEN_NONE;
        if ((b & MASK_LEAD2) == PAT_LEAD2) begin
            len = LEN_TWO;
        end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
            len = LEN_THREE;
        end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & MASK_CONT) == PAT_CONT;
    endfunction

endpackage

// ===== rtl/core/utf8_sequence_filter_top.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sequence filter
// Passes well-formed UTF-8 sequences of a message, drops broken, truncated
// and stray bytes, and marks the last result of each message.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_in_byte, s_message_last
//  m_      | out       | m_valid / m_ready  | m_out_byte, m_byte_valid,
//          |           |                    | m_run_last, m_message_end
//
//  One byte is taken per cycle while s_ready is high; results leave one per
//  cycle while m_ready is high from a burst queue, so a byte's first result
//  shows once its burst is registered there, later when older bursts are queued.
//  s_ready drops only while the queue of QUEUE_DEPTH bursts is full.
//  Synchronous active-low reset clears sequence state and empties the queue.
// ----------------------------------------------------------------------------
module utf8_sequence_filter_top #(
    parameter int unsigned QUEUE_DEPTH = ufs_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_message_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_run_last,
    output logic       m_message_end
);

    ufs_pkg::ufs_burst_t burst, head;
    logic                push, pop, q_empty, q_full;

    ufs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_message_last(s_message_last),
        .q_full        (q_full),
        .push          (push),
        .burst         (burst)
    );

    ufs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(burst),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    ufs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_run_last   (m_run_last),
        .m_message_end(m_message_end)
    );

endmodule

// ===== rtl/core/ufs_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sequence filter front end
// Accepts bytes, tracks the open sequence and emits one burst per byte
// that releases results or ends a message.
// ----------------------------------------------------------------------------
module ufs_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_in_byte,
    input  logic                s_message_last,
    input  logic                q_full,
    output logic                push,
    output ufs_pkg::ufs_burst_t burst
);

    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];
    logic [2:0] exp_len_reg, exp_len_next;
    logic [1:0] held_cnt_reg, held_cnt_next;
    logic [2:0] n_res;
    logic       judge;
    logic       accept;
    logic [2:0] lead_len;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign lead_len = ufs_pkg::lead_length(s_in_byte);

    // Classify the byte and build the burst of results it releases
    always_comb begin
        held_next     = held_reg;
        exp_len_next  = exp_len_reg;
        held_cnt_next = held_cnt_reg;
        n_res         = 3'd0;
        judge         = 1'b1;
        burst         = '0;

        if (exp_len_reg != ufs_pkg::LEN_NONE) begin
            if (ufs_pkg::is_cont(s_in_byte)) begin
                judge = 1'b0;
                if (({1'b0, held_cnt_reg} + 3'd1) >= exp_len_reg) begin
                    // release held bytes followed by this one
                    n_res = {1'b0, held_cnt_reg} + 3'd1;
                    for (int i = 0; i < 4; i++) begin
                        if (i < 3 && 2'(i) < held_cnt_reg) begin
                            burst.bytes[i] = held_reg[i];
                        end else begin
                            burst.bytes[i] = s_in_byte;
                        end
                    end
                    exp_len_next  = ufs_pkg::LEN_NONE;
                    held_cnt_next = 2'd0;
                end else begin
                    held_next[held_cnt_reg] = s_in_byte;
                    held_cnt_next           = held_cnt_reg + 2'd1;
                end
            end else begin
                // broken sequence: drop what is held
                exp_len_next  = ufs_pkg::LEN_NONE;
                held_cnt_next = 2'd0;
            end
        end

        // Judge the byte afresh
        if (judge) begin
            if (s_in_byte <= ufs_pkg::ASCII_MAX) begin
                n_res          = 3'd1;
                burst.bytes[0] = s_in_byte;
            end else if (lead_len != ufs_pkg::LEN_NONE) begin
                held_next[0]  = s_in_byte;
                held_cnt_next = 2'd1;
                exp_len_next  = lead_len;
            end
        end

        burst.data_valid = 1'b1;
        burst.msg_end    = s_message_last;
        if (s_message_last) begin
            // truncated sequence is dropped at message end
            exp_len_next  = ufs_pkg::LEN_NONE;
            held_cnt_next = 2'd0;
            if (n_res == 3'd0) begin
                n_res            = 3'd1;
                burst.bytes[0]   = 8'h00;
                burst.data_valid = 1'b0;
            end
        end
        burst.last_idx = 2'(n_res - 3'd1);
    end

    assign push = accept && (n_res != 3'd0);

    // Advance sequence state on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_len_reg  <= ufs_pkg::LEN_NONE;
            held_cnt_reg <= 2'd0;
        end else if (accept) begin
            exp_len_reg  <= exp_len_next;
            held_cnt_reg <= held_cnt_next;
        end
    end

    // Held bytes need no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== rtl/core/ufs_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sequence filter burst queue
// Small register FIFO of bursts between front and back.
// ----------------------------------------------------------------------------
module ufs_queue #(
    parameter int unsigned DEPTH = ufs_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ufs_pkg::ufs_burst_t push_data,
    input  logic                pop,
    output ufs_pkg::ufs_burst_t head,
    output logic                empty,
    output logic                full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ufs_pkg::ufs_burst_t mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Store burst
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/ufs_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sequence filter back end
// Walks the head burst and delivers one result per transfer.
// ----------------------------------------------------------------------------
module ufs_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  ufs_pkg::ufs_burst_t head,
    input  logic                q_empty,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_byte_valid,
    output logic                m_run_last,
    output logic                m_message_end
);

    logic [1:0] idx_reg;
    logic       xfer;

    assign m_valid       = !q_empty;
    assign m_out_byte    = head.bytes[idx_reg];
    assign m_byte_valid  = head.data_valid;
    assign m_run_last    = (idx_reg == head.last_idx);
    assign m_message_end = m_run_last && head.msg_end;
    assign xfer          = m_valid && m_ready;
    assign pop           = xfer && m_run_last;

    // Advance within the burst, rewind on its last transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else if (xfer) begin
            idx_reg <= m_run_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule

// ===== rtl/core/ufs_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sequence filter port checker
// Watches the top level ports for result framing and output stability.
// ----------------------------------------------------------------------------
module ufs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_byte_valid,
    input logic       m_run_last,
    input logic       m_message_end
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_run_last))
        else $error("stalled result changed");

    // Message end closes the run of its byte
    a_end_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_message_end |-> m_run_last)
        else $error("message end without run last");

    // Empty marker is a zero byte ending the message
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_run_last && m_message_end && (m_out_byte == 8'h00))
        else $error("malformed end marker");

    // Reset empties the result side
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown after reset");

endmodule

bind utf8_sequence_filter_top ufs_checker u_ufs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_byte   (m_out_byte),
    .m_byte_valid (m_byte_valid),
    .m_run_last   (m_run_last),
    .m_message_end(m_message_end)
);

// ===== tb/sv/utf8_sequence_filter_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sequence filter testbench
// Drives byte messages through the filter over valid/ready with random idle
// cycles on both sides and checks every result against a byte-level model,
// or typed rows against their table entry. A directed table covers extremes,
// broken, truncated and stray cases; random messages of mostly well-formed
// sequences follow; a long receiver stall fills the queue so its input stalls.
// ----------------------------------------------------------------------------
module utf8_sequence_filter_top_tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int MAX_RESULTS    = 4;
    localparam int DIRECTED_ROWS  = 26;
    localparam int PRESSURE_BYTES = 24;
    localparam int RANDOM_ITEMS   = 110;
    localparam int STALL_CYCLES   = 200;
    localparam int MAX_GAP        = 15;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 200000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       message_end;
    } filter_result_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       msg_last;
        logic       typed;
        logic [7:0] exp_byte;
        logic       exp_valid;
        logic       exp_end;
    } stim_row_t;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte      = 8'h00;
    logic       s_message_last = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_run_last;
    logic       m_message_end;

    // Side information held alongside the payload of the current transfer
    logic           row_typed = 1'b0;
    filter_result_t row_result = '0;

    // Filter model state
    logic [7:0] seq_bytes [3];
    logic [2:0] seq_len   = ufs_pkg::LEN_NONE;
    logic [1:0] seq_count = 2'd0;

    filter_result_t expected_results [$];
    stim_row_t      directed_rows [DIRECTED_ROWS];

    int error_count  = 0;
    int results_seen = 0;
    int items_sent   = 0;
    int cycle_count  = 0;
    bit sender_idle  = 1'b1;
    bit recv_idle    = 1'b1;
    bit stall_request = 1'b0;

    utf8_sequence_filter_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_message_last (s_message_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_run_last     (m_run_last),
        .m_message_end  (m_message_end)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s at result %0d: got %0h, expected %0h",
                 what, results_seen, got, want);
        error_count++;
    endtask

    // Advance the filter model by one byte and queue the results it yields
    task automatic filter_model_step(input logic [7:0] b, input logic last,
                                     input bit keep);
        filter_result_t res [MAX_RESULTS];
        int         n;
        bit         judge;
        logic [2:0] len;
        n     = 0;
        judge = 1'b1;
        len   = ufs_pkg::LEN_NONE;
        if (seq_len != ufs_pkg::LEN_NONE) begin
            if ((b & ufs_pkg::MASK_CONT) == ufs_pkg::PAT_CONT) begin
                judge = 1'b0;
                if (int'(seq_count) + 1 >= int'(seq_len)) begin
                    // Release the whole sequence in order
                    for (int k = 0; k < int'(seq_count); k++) begin
                        res[n] = '{seq_bytes[k], 1'b1, 1'b0, 1'b0};
                        n++;
                    end
                    res[n] = '{b, 1'b1, 1'b0, 1'b0};
                    n++;
                    seq_len   = ufs_pkg::LEN_NONE;
                    seq_count = 2'd0;
                end else begin
                    seq_bytes[seq_count] = b;
                    seq_count            = seq_count + 2'd1;
                end
            end else begin
                // Drop the broken sequence, then judge this byte afresh
                seq_len   = ufs_pkg::LEN_NONE;
                seq_count = 2'd0;
            end
        end
        if (judge) begin
            if (b <= ufs_pkg::ASCII_MAX) begin
                res[n] = '{b, 1'b1, 1'b0, 1'b0};
                n++;
            end else if ((b & ufs_pkg::MASK_LEAD2) == ufs_pkg::PAT_LEAD2) begin
                len = ufs_pkg::LEN_TWO;
            end else if ((b & ufs_pkg::MASK_LEAD3) == ufs_pkg::PAT_LEAD3) begin
                len = ufs_pkg::LEN_THREE;
            end else if ((b & ufs_pkg::MASK_LEAD4) == ufs_pkg::PAT_LEAD4) begin
                len = ufs_pkg::LEN_FOUR;
            end
            if (len != ufs_pkg::LEN_NONE) begin
                seq_bytes[0] = b;
                seq_count    = 2'd1;
                seq_len      = len;
            end
        end
        if (last) begin
            // Drop a sequence cut off by the end of the message
            seq_len   = ufs_pkg::LEN_NONE;
            seq_count = 2'd0;
            if (n == 0) begin
                res[0] = '{8'h00, 1'b0, 1'b0, 1'b0};
                n      = 1;
            end
            res[n-1].message_end = 1'b1;
        end
        if (n > 0) begin
            res[n-1].run_last = 1'b1;
        end
        if (keep) begin
            for (int k = 0; k < n; k++) begin
                expected_results.insert(expected_results.size(), res[k]);
            end
        end
    endtask

    // Check each result transfer and predict each input transfer
    always @(posedge aclk) begin
        filter_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, out_byte", m_out_byte, 8'h00);
                end else begin
                    want = expected_results.pop_front();
                    if (m_out_byte !== want.out_byte)
                        report_mismatch("out_byte", m_out_byte, want.out_byte);
                    if (m_byte_valid !== want.byte_valid)
                        report_mismatch("byte_valid", 8'(m_byte_valid), 8'(want.byte_valid));
                    if (m_run_last !== want.run_last)
                        report_mismatch("run_last", 8'(m_run_last), 8'(want.run_last));
                    if (m_message_end !== want.message_end)
                        report_mismatch("message_end", 8'(m_message_end),
                                        8'(want.message_end));
                end
            end
            if (s_valid && s_ready) begin
                filter_model_step(s_in_byte, s_message_last, !row_typed);
                if (row_typed) begin
                    expected_results.insert(expected_results.size(), row_result);
                end
            end
        end
    end

    // Receiver: random ready gaps per result, plus one long hold-off on request
    initial begin : receiver
        int gap;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (stall_request) begin
                m_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge aclk);
                stall_request = 1'b0;
            end
            if ($urandom_range(0, 19) == 0) begin
                recv_idle = !recv_idle;
            end
            gap = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Offer one byte after a random gap and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input filter_result_t typed_result);
        int gap;
        gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_in_byte      <= b;
        s_message_last <= last;
        row_typed      <= typed;
        row_result     <= typed_result;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Lower valid and hold until every expected result has arrived
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] random_cont();
        return ufs_pkg::PAT_CONT | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [7:0] random_lead(input int len);
        if (len == 2) return ufs_pkg::PAT_LEAD2 | 8'($urandom_range(0, 31));
        if (len == 3) return ufs_pkg::PAT_LEAD3 | 8'($urandom_range(0, 15));
        return ufs_pkg::PAT_LEAD4 | 8'($urandom_range(0, 7));
    endfunction

    // Build a random message of mostly well-formed characters and send it
    task automatic send_random_message();
        logic [7:0] msg [$];
        int chunks;
        int len;
        sender_idle = ($urandom_range(0, 3) != 0);
        chunks      = $urandom_range(1, 6);
        repeat (chunks) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: msg = {msg, 8'($urandom_range(0, 127))};
                4, 5, 6: begin
                    len = $urandom_range(2, 4);
                    msg = {msg, random_lead(len)};
                    repeat (len - 1) msg = {msg, random_cont()};
                end
                7: begin
                    if ($urandom_range(0, 1) == 1) begin
                        msg = {msg, random_cont()};
                    end else begin
                        msg = {msg, 8'($urandom_range(8'hF8, 8'hFF))};
                    end
                end
                8: begin
                    // Short sequence: broken by the next byte or cut by the end
                    len = $urandom_range(2, 4);
                    msg = {msg, random_lead(len)};
                    repeat ($urandom_range(0, len - 2)) msg = {msg, random_cont()};
                end
                default: msg = {msg, 8'($urandom_range(0, 255))};
            endcase
        end
        foreach (msg[i]) begin
            send_byte(msg[i], i == msg.size() - 1, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        bit paused_once;
        paused_once = 1'b0;
        directed_rows = '{
            // extremes with one obvious result
            '{8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1},
            '{8'h7F, 1'b0, 1'b1, 8'h7F, 1'b1, 1'b0},
            // stray continuation and top stray byte ending messages: empty marker
            '{8'h80, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
            '{8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
            '{8'hF8, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            // two, three and four byte sequences
            '{8'hC2, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'hA9, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'hE2, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h82, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'hAC, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'hF0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h9F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h98, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h80, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
            // broken by an ASCII byte, then by a new lead
            '{8'hC3, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h41, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'hE0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'hC5, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'hBF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            // truncated by the end of the message
            '{8'hF4, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'h8F, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
            // lead on the last byte
            '{8'hDF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1},
            // highest four byte lead: four results from one byte
            '{8'hF7, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'hBF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'hBF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
            '{8'hBF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].in_byte, directed_rows[i].msg_last,
                      directed_rows[i].typed,
                      '{directed_rows[i].exp_byte, directed_rows[i].exp_valid, 1'b1,
                        directed_rows[i].exp_end});
        end
        wait_results_drained();

        // Hold off the receiver while bytes keep coming back to back
        stall_request = 1'b1;
        sender_idle   = 1'b0;
        for (int i = 0; i < PRESSURE_BYTES; i++) begin
            send_byte(8'($urandom_range(0, 127)), i == PRESSURE_BYTES - 1, 1'b0, '0);
        end

        // Random messages, with one pause for a full drain halfway
        while (items_sent < DIRECTED_ROWS + PRESSURE_BYTES + RANDOM_ITEMS) begin
            if (!paused_once &&
                items_sent >= DIRECTED_ROWS + PRESSURE_BYTES + RANDOM_ITEMS / 2) begin
                wait_results_drained();
                paused_once = 1'b1;
            end
            send_random_message();
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
